@@ src/wrsc_pkg.sv @@
// types, constants and helpers shared by the relay schedule controller
package wrsc_pkg;

	localparam int TABLE_DEPTH = 16;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = 5;
	localparam int ENTRY_W = 15;
	localparam logic [15:0] DURATION_RESET = 16'd1800;
	localparam logic [13:0] WEEK_MINUTES = 14'd10080;
	localparam logic [13:0] DAY_MINUTES = 14'd1440;

	typedef enum logic [3:0] {
		ACT_TICK   = 4'd0,
		ACT_ON     = 4'd1,
		ACT_OFF    = 4'd2,
		ACT_AUTO   = 4'd3,
		ACT_STATUS = 4'd4,
		ACT_CLEAR  = 4'd5,
		ACT_ADD    = 4'd6,
		ACT_DELETE = 4'd7,
		ACT_READ   = 4'd8
	} action_t;

	localparam logic [1:0] MODE_AUTO = 2'd0;
	localparam logic [1:0] MODE_FON  = 2'd1;
	localparam logic [1:0] MODE_FOFF = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_BAD   = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	typedef struct packed {
		logic [3:0]  action;
		logic        time_valid;
		logic [2:0]  now_day;
		logic [4:0]  now_hour;
		logic [5:0]  now_minute;
		logic [31:0] now_seconds;
		logic [3:0]  entry_day;
		logic [4:0]  entry_hour;
		logic [5:0]  entry_minute;
		logic        entry_switch_on;
		logic [3:0]  entry_index;
	} cmd_t;

	typedef struct packed {
		logic       relay_on;
		logic [1:0] mode;
		logic [4:0] entry_count;
		logic [1:0] status;
		logic [2:0] read_day;
		logic [4:0] read_hour;
		logic [5:0] read_minute;
		logic       read_switch_on;
	} result_t;

	typedef enum logic [2:0] {
		S_IDLE, S_APPLY, S_RESTORE, S_DEL, S_READ, S_DONE
	} state_t;

	// entry layout: day[14:12] hour[11:7] minute[6:1] on[0]
	function automatic logic [2:0] e_day(input logic [ENTRY_W-1:0] e);
		return e[14:12];
	endfunction
	function automatic logic [4:0] e_hour(input logic [ENTRY_W-1:0] e);
		return e[11:7];
	endfunction
	function automatic logic [5:0] e_min(input logic [ENTRY_W-1:0] e);
		return e[6:1];
	endfunction

	// hour * 60 + minute, inputs up to 31 and 63
	function automatic logic [13:0] minute_of_day(input logic [4:0] h, input logic [5:0] m);
		return 14'({h, 6'd0} - {h, 2'd0}) + 14'(m);
	endfunction

endpackage

@@ src/weekly_relay_schedule_controller.sv @@
// top level of the weekly relay schedule controller
// Usage: drive cmd and pulse start while busy is low; the item is taken on
// that edge and busy rises. One result appears on result with done high for
// a single cycle; the receiver cannot hold it off and must take it then.
// cfg_we writes override_duration (reset 1800); the user must write it
// only while the block is idle, as the block itself does not enforce it.
// Status, force, auto, clear, add, a tick with no table walk, and a
// delete or read whose index is out of range go straight to done. Read
// does one memory read first. A tick that applies matches walks the
// table one entry a cycle. A restore reads each entry and then visits
// its days, one day for a weekday entry and seven for a daily one.
// Delete moves each later entry down by one, reading it in a read phase
// and writing it one slot lower in a write phase. The table lives in one
// single-port ram with a registered read. busy falls after the done
// cycle, and the next item can be taken once it is low.
// Reset clears the count, mode, relay and minute tracking; table contents
// are undefined but unused until written. One item at a time.
module weekly_relay_schedule_controller
	import wrsc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  wrsc_pkg::cmd_t           cmd,
	output logic                     busy,
	output logic                     done,
	output wrsc_pkg::result_t        result,
	input  logic                     cfg_we,
	input  logic [15:0]              cfg_wdata
);
	state_t state_q, state_d;
	cmd_t cmd_q;
	logic [15:0] dur_q;
	logic [CNT_W-1:0] count_q;
	logic relay_q, known_q;
	logic [1:0] mode_q, status_q;
	logic [31:0] deadline_q;
	logic [13:0] last_q;
	logic [CNT_W-1:0] ptr_q;
	logic [2:0] dsel_q;
	logic rd_pend_q, phase_q;
	logic found_q, act_q;
	logic [16:0] best_q;
	logic [ENTRY_W-1:0] rd_ent_q;

	logic we;
	logic [IDX_W-1:0] addr;
	logic [ENTRY_W-1:0] wdata, rdata;
	logic match;
	logic [16:0] ago;
	logic [2:0] d1;
	logic [2:0] dstart;

	logic [31:0] since_dl;
	logic expired, kn_now, idx_ok, add_ok, go_restore, go_apply;
	logic [1:0] md_now, status_d;
	logic [13:0] mod_now;

	wrsc_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	wrsc_scan u_scan (
		.entry(rdata), .now_day(cmd_q.now_day), .now_hour(cmd_q.now_hour),
		.now_minute(cmd_q.now_minute), .day_sel(dstart), .match(match), .ago(ago)
	);

	assign busy = (state_q != S_IDLE);
	// a daily entry visits days 0 to 6, a weekday entry only its own day
	assign d1 = (e_day(rdata) == 3'd7) ? 3'd6 : 3'd0;
	assign dstart = (e_day(rdata) == 3'd7) ? dsel_q : e_day(rdata);

	// decode of the item at the input
	always_comb begin
		since_dl = cmd.now_seconds - deadline_q;
		expired = (mode_q != MODE_AUTO) && !since_dl[31];
		md_now = expired ? MODE_AUTO : mode_q;
		kn_now = expired ? 1'b0 : known_q;
		mod_now = minute_of_day(cmd.now_hour, cmd.now_minute);
		go_restore = cmd.time_valid && !kn_now && md_now == MODE_AUTO && count_q != '0;
		go_apply = cmd.time_valid && kn_now && mod_now != last_q
			&& md_now == MODE_AUTO && count_q != '0;
		idx_ok = 5'(cmd.entry_index) < count_q;
		add_ok = 1'b0;
		status_d = ST_OK;
		case (cmd.action)
			ACT_ADD: begin
				if (32'(count_q) >= TABLE_DEPTH) status_d = ST_FULL;
				else if (cmd.entry_day > 4'd7 || cmd.entry_hour > 5'd23
					|| cmd.entry_minute > 6'd59) status_d = ST_BAD;
				else add_ok = 1'b1;
			end
			ACT_DELETE, ACT_READ: if (!idx_ok) status_d = ST_RANGE;
			ACT_TICK, ACT_ON, ACT_OFF, ACT_AUTO, ACT_STATUS, ACT_CLEAR: ;
			default: status_d = ST_BAD;
		endcase
	end

	// ram port control
	always_comb begin
		we = 1'b0;
		addr = ptr_q[IDX_W-1:0];
		wdata = rdata;
		if (state_q == S_IDLE && start && cmd.action == ACT_ADD) begin
			addr = count_q[IDX_W-1:0];
			wdata = {cmd.entry_day[2:0], cmd.entry_hour, cmd.entry_minute, cmd.entry_switch_on};
			we = add_ok;
		end else if (state_q == S_IDLE && start) begin
			addr = cmd.entry_index[IDX_W-1:0];
		end else if (state_q == S_DEL && phase_q) begin
			addr = IDX_W'(ptr_q - 5'd1);
			we = 1'b1;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_DONE;
					case (cmd.action)
						ACT_TICK: begin
							if (go_restore) state_d = S_RESTORE;
							else if (go_apply) state_d = S_APPLY;
						end
						ACT_DELETE: if (idx_ok) state_d = S_DEL;
						ACT_READ:   if (idx_ok) state_d = S_READ;
						default: ;
					endcase
				end
			end
			S_APPLY:   if (!rd_pend_q && ptr_q >= count_q) state_d = S_DONE;
			S_RESTORE: if (!rd_pend_q && ptr_q >= count_q) state_d = S_DONE;
			S_DEL:     if (!phase_q && ptr_q >= count_q) state_d = S_DONE;
			S_READ:    state_d = S_DONE;
			S_DONE:    state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		done = (state_q == S_DONE);
		result = '0;
		result.relay_on = relay_q;
		result.mode = mode_q;
		result.entry_count = count_q;
		result.status = status_q;
		if (cmd_q.action == ACT_READ && status_q == ST_OK) begin
			result.read_day = e_day(rd_ent_q);
			result.read_hour = e_hour(rd_ent_q);
			result.read_minute = e_min(rd_ent_q);
			result.read_switch_on = rd_ent_q[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dur_q <= DURATION_RESET;
			count_q <= '0;
			relay_q <= 1'b0;
			mode_q <= MODE_AUTO;
			deadline_q <= '0;
			last_q <= '0;
			known_q <= 1'b0;
			status_q <= ST_OK;
			ptr_q <= '0;
			dsel_q <= '0;
			rd_pend_q <= 1'b0;
			phase_q <= 1'b0;
			found_q <= 1'b0;
			act_q <= 1'b0;
			best_q <= '0;
		end else begin
			if (cfg_we) dur_q <= cfg_wdata;
			state_q <= state_d;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						status_q <= status_d;
						ptr_q <= (cmd.action == ACT_DELETE) ? 5'(cmd.entry_index) + 5'd1 : '0;
						rd_pend_q <= 1'b0;
						dsel_q <= '0;
						found_q <= 1'b0;
						phase_q <= 1'b0;
						case (cmd.action)
							ACT_TICK: begin
								if (expired) begin
									mode_q <= MODE_AUTO;
									deadline_q <= '0;
								end
								if (cmd.time_valid && !kn_now) known_q <= 1'b1;
								else if (expired) known_q <= 1'b0;
								if (cmd.time_valid) begin
									if (!kn_now) begin
										last_q <= mod_now;
										if (md_now == MODE_FON) relay_q <= 1'b1;
										else if (md_now == MODE_FOFF) relay_q <= 1'b0;
										else if (count_q == '0) relay_q <= 1'b0;
									end else if (mod_now != last_q) begin
										last_q <= mod_now;
									end
								end
							end
							ACT_ON, ACT_OFF: begin
								mode_q <= cmd.action[1:0];
								deadline_q <= cmd.now_seconds + 32'(dur_q);
								relay_q <= (cmd.action == ACT_ON);
							end
							ACT_AUTO: begin
								mode_q <= MODE_AUTO;
								deadline_q <= '0;
								known_q <= 1'b0;
							end
							ACT_CLEAR: count_q <= '0;
							ACT_ADD: if (add_ok) count_q <= count_q + 5'd1;
							default: ;
						endcase
					end
				end
				S_APPLY: begin
					// read issued at ptr, evaluated in the cycle after
					if (rd_pend_q && match) relay_q <= rdata[0];
					rd_pend_q <= (ptr_q < count_q);
					if (ptr_q < count_q) ptr_q <= ptr_q + 5'd1;
				end
				S_RESTORE: begin
					// ptr stays on an entry while its days are visited
					if (rd_pend_q) begin
						if (!found_q || ago < best_q) begin
							found_q <= 1'b1;
							best_q <= ago;
							act_q <= rdata[0];
						end
						if (dsel_q < d1) begin
							dsel_q <= dsel_q + 3'd1;
						end else begin
							ptr_q <= ptr_q + 5'd1;
							rd_pend_q <= 1'b0;
							dsel_q <= 3'd0;
						end
					end else if (ptr_q < count_q) begin
						rd_pend_q <= 1'b1;
						dsel_q <= 3'd0;
					end else begin
						relay_q <= act_q;
					end
				end
				S_DEL: begin
					// phase 0 reads ptr, phase 1 writes it to ptr-1
					if (!phase_q) begin
						if (ptr_q < count_q) phase_q <= 1'b1;
						else count_q <= count_q - 5'd1;
					end else begin
						phase_q <= 1'b0;
						ptr_q <= ptr_q + 5'd1;
					end
				end
				S_READ: ;
				S_DONE: ;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) cmd_q <= cmd;
		if (state_q == S_READ) rd_ent_q <= rdata;
	end
endmodule

@@ src/wrsc_ram.sv @@
// generic single-port ram with registered read
module wrsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

@@ src/wrsc_scan.sv @@
// per-entry restore distance and match test for one table entry
module wrsc_scan
	import wrsc_pkg::*;
(
	input  logic [ENTRY_W-1:0] entry,
	input  logic [2:0]         now_day,
	input  logic [4:0]         now_hour,
	input  logic [5:0]         now_minute,
	input  logic [2:0]         day_sel,
	output logic               match,
	output logic [16:0]        ago
);
	logic [16:0] cur, at;

	always_comb begin
		match = (e_hour(entry) == now_hour) && (e_min(entry) == now_minute)
			&& ((e_day(entry) == 3'd7) || (e_day(entry) == now_day));
		cur = 17'(now_day) * 17'(DAY_MINUTES) + 17'(minute_of_day(now_hour, now_minute));
		at  = 17'(day_sel) * 17'(DAY_MINUTES) + 17'(minute_of_day(e_hour(entry), e_min(entry)));
		if (cur >= at) begin
			ago = cur - at;
		end else begin
			ago = cur + 17'(WEEK_MINUTES) - at;
		end
	end
endmodule
